// ===== rtl/cbc_pkg.sv =====
// Package with the shared types and constants of the cartridge bank controller.
package cbc_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_LIMIT_DEF = 128;
  localparam int RAM_BANK_LIMIT_DEF = 4;

  localparam int ROM_OFS_W = 14;
  localparam int RAM_OFS_W = 13;
  localparam int BANK_NUM_W = 7;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 1'd1;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_LOAD = 2'd2;

  localparam logic [7:0] FAULT_BYTE = 8'hFF;
  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data_byte;
    logic [20:0] rom_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_fault;
  } out_item_t;

endpackage

// ===== rtl/cartridge_bank_controller_core.sv =====
// Top level of the cartridge bank controller with its ROM and RAM memories.
//
// The input channel (in_valid, in_stall, in_data) carries bus reads, bus writes and
// ROM image byte loads; a transaction is taken when in_valid is high and in_stall low.
// Only a bus read produces a transaction on the output channel (out_valid, out_stall,
// out_data). Writes below 0x8000 update the bank registers, writes to 0xA000-0xBFFF
// update external RAM when it is enabled, and loads fill the ROM image.
// The configuration port (cfg_we, cfg_index, cfg_data) sets the ROM bank mask and the
// RAM bank count; write it only while the block is idle.
// A read is looked up in the ROM or RAM memory, whose synchronous port returns data at
// the edge that takes the read; the result then passes from the memory read register
// into the output register, which drives out_valid. One transaction is accepted per
// cycle while the output drains.
// When the receiver stalls, one read can wait in the memory read register behind the
// held result; further input is then stalled until the output moves.
// After reset the block clears all RAM_BANK_LIMIT * 8192 bytes of external RAM one byte
// per cycle; in_stall stays high during that pass.
module cartridge_bank_controller_core #(
  parameter int ROM_BANK_LIMIT = cbc_pkg::ROM_BANK_LIMIT_DEF,
  parameter int RAM_BANK_LIMIT = cbc_pkg::RAM_BANK_LIMIT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cbc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cbc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [cbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ROM_DEPTH = ROM_BANK_LIMIT * cbc_pkg::ROM_BANK_BYTES;
  localparam int RAM_DEPTH = RAM_BANK_LIMIT * cbc_pkg::RAM_BANK_BYTES;
  localparam int ROM_AW = $clog2(ROM_DEPTH);
  localparam int RAM_AW = $clog2(RAM_DEPTH);
  localparam int ROM_BW = (ROM_BANK_LIMIT > 1) ? $clog2(ROM_BANK_LIMIT) : 1;
  localparam int RAM_BW = (RAM_BANK_LIMIT > 1) ? $clog2(RAM_BANK_LIMIT) : 1;
  localparam int ROM_BANKS_IN = 1 << cbc_pkg::BANK_NUM_W;
  localparam int RAM_BANKS_IN = 4;
  localparam logic [21:0] ROM_TOTAL = 22'(ROM_DEPTH);
  localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_DEPTH - 1);

  typedef enum logic [1:0] {SRC_ROM, SRC_RAM, SRC_FAULT} src_t;

  logic [7:0] rom_mem [ROM_DEPTH];
  logic [7:0] ram_mem [RAM_DEPTH];

  logic [ROM_BW-1:0] rom_wrap_tbl [ROM_BANKS_IN];
  logic [RAM_BW-1:0] ram_wrap_tbl [RAM_BANKS_IN];

  for (genvar i = 0; i < ROM_BANKS_IN; i++) begin : g_rom_wrap
    assign rom_wrap_tbl[i] = ROM_BW'(i % ROM_BANK_LIMIT);
  end
  for (genvar i = 0; i < RAM_BANKS_IN; i++) begin : g_ram_wrap
    assign ram_wrap_tbl[i] = RAM_BW'(i % RAM_BANK_LIMIT);
  end

  logic [6:0]        rom_bank_mask_r;
  logic [2:0]        ram_bank_count_r;
  logic              ram_enable_r;
  logic              banking_mode_r;
  logic [4:0]        low_bank_r;
  logic [1:0]        high_bank_r;
  logic              clearing_r;
  logic [RAM_AW-1:0] clr_addr_r;
  logic              pend_r;
  src_t              pend_src_r;
  logic [7:0]        rom_q_r;
  logic [7:0]        ram_q_r;
  logic              out_valid_r;
  cbc_pkg::out_item_t out_data_r;

  logic              accept;
  logic              pend_move;
  logic              ram_usable;
  logic              in_rom0;
  logic              in_rom1;
  logic              in_ram;
  logic [6:0]        rom_bank_raw;
  logic [ROM_BW-1:0] rom_bank;
  logic [1:0]        ram_bank_raw;
  logic [RAM_BW-1:0] ram_bank;
  logic [ROM_AW-1:0] rom_raddr;
  logic [RAM_AW-1:0] ram_addr;
  logic              rom_re;
  logic              rom_we;
  logic              ram_re;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              is_read;
  logic              is_write;
  src_t              src_nxt;
  cbc_pkg::out_item_t out_nxt;

  assign pend_move = pend_r && (!out_valid_r || !out_stall);
  assign in_stall  = clearing_r || (pend_r && !pend_move);
  assign accept    = in_valid && !in_stall;
  assign is_read   = accept && (in_data.kind == cbc_pkg::KIND_READ);
  assign is_write  = accept && (in_data.kind == cbc_pkg::KIND_WRITE);

  assign ram_usable = ram_enable_r && (ram_bank_count_r != 3'd0);
  assign in_rom0 = in_data.address inside {[16'h0000 : 16'h3FFF]};
  assign in_rom1 = in_data.address inside {[16'h4000 : 16'h7FFF]};
  assign in_ram  = (in_data.address inside {[16'hA000 : 16'hBFFF]}) && ram_usable;

  always_comb begin
    if (in_rom0) begin
      rom_bank_raw = banking_mode_r ? {high_bank_r, 5'd0} & rom_bank_mask_r : 7'd0;
    end else begin
      rom_bank_raw = {high_bank_r, low_bank_r} & rom_bank_mask_r;
    end
    if (banking_mode_r && (ram_bank_count_r != 3'd0)) begin
      ram_bank_raw = high_bank_r & 2'(ram_bank_count_r - 3'd1);
    end else begin
      ram_bank_raw = 2'd0;
    end
  end

  assign rom_bank  = rom_wrap_tbl[rom_bank_raw];
  assign ram_bank  = ram_wrap_tbl[ram_bank_raw];
  assign rom_raddr = ROM_AW'({rom_bank, in_data.address[cbc_pkg::ROM_OFS_W-1:0]});
  assign ram_addr  = RAM_AW'({ram_bank, in_data.address[cbc_pkg::RAM_OFS_W-1:0]});

  assign rom_re = is_read && (in_rom0 || in_rom1);
  assign ram_re = is_read && in_ram;
  assign rom_we = accept && (in_data.kind == cbc_pkg::KIND_LOAD) &&
                  ({1'b0, in_data.rom_offset} < ROM_TOTAL);
  assign ram_we = clearing_r || (is_write && in_ram);
  assign ram_waddr = clearing_r ? clr_addr_r : ram_addr;
  assign ram_wdata = clearing_r ? 8'd0 : in_data.data_byte;

  always_comb begin
    if (in_rom0 || in_rom1) begin
      src_nxt = SRC_ROM;
    end else if (in_ram) begin
      src_nxt = SRC_RAM;
    end else begin
      src_nxt = SRC_FAULT;
    end
    case (pend_src_r)
      SRC_ROM: begin
        out_nxt.read_data  = rom_q_r;
        out_nxt.read_fault = 1'b0;
      end
      SRC_RAM: begin
        out_nxt.read_data  = ram_q_r;
        out_nxt.read_fault = 1'b0;
      end
      default: begin
        out_nxt.read_data  = cbc_pkg::FAULT_BYTE;
        out_nxt.read_fault = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[ROM_AW'(in_data.rom_offset)] <= in_data.data_byte;
    end
    if (rom_re) begin
      rom_q_r <= rom_mem[rom_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_q_r <= ram_mem[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_mask_r  <= 7'd1;
      ram_bank_count_r <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbc_pkg::CFG_ROM_BANK_MASK:  rom_bank_mask_r  <= cfg_data;
        cbc_pkg::CFG_RAM_BANK_COUNT: ram_bank_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r   <= 1'b0;
      banking_mode_r <= 1'b0;
      low_bank_r     <= 5'd1;
      high_bank_r    <= 2'd0;
    end else if (is_write) begin
      if (in_data.address inside {[16'h0000 : 16'h1FFF]}) begin
        ram_enable_r <= (ram_bank_count_r != 3'd0) &&
                        (in_data.data_byte[3:0] == cbc_pkg::RAM_ENABLE_KEY);
      end else if (in_data.address inside {[16'h2000 : 16'h3FFF]}) begin
        low_bank_r <= (in_data.data_byte[4:0] == 5'd0) ? 5'd1 : in_data.data_byte[4:0];
      end else if (in_data.address inside {[16'h4000 : 16'h5FFF]}) begin
        high_bank_r <= in_data.data_byte[1:0];
      end else if (in_data.address inside {[16'h6000 : 16'h7FFF]}) begin
        banking_mode_r <= in_data.data_byte[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + RAM_AW'(1);
      if (clr_addr_r == RAM_LAST) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (is_read) begin
        pend_r <= 1'b1;
      end else if (pend_move) begin
        pend_r <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read) begin
      pend_src_r <= src_nxt;
    end
    if (pend_move) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/cbc_checker.sv =====
// Port-level checker for the cartridge bank controller and its bind statement.
module cbc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input cbc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input cbc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled output transaction was dropped");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input transaction changed");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input accepted during RAM clearing pass");

  a_fault_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_fault |-> out_data.read_data == cbc_pkg::FAULT_BYTE)
    else $error("faulted read does not return 0xFF");

endmodule

bind cartridge_bank_controller_core cbc_checker u_cbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/cartridge_bank_controller_core_test.sv =====
// Self-checking testbench for the cartridge bank controller core.
`timescale 1ns / 100ps

module cartridge_bank_controller_core_test;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [15:0] ENABLE_TOP = 16'h1FFF;
  localparam logic [15:0] LOW_BANK_TOP = 16'h3FFF;
  localparam logic [15:0] BANK1_BASE = 16'h4000;
  localparam logic [15:0] HIGH_BANK_TOP = 16'h5FFF;
  localparam logic [15:0] ROM_TOP = 16'h7FFF;
  localparam logic [15:0] RAM_BASE = 16'hA000;
  localparam logic [15:0] RAM_TOP = 16'hBFFF;
  localparam logic [15:0] ROM_OFS_MASK = 16'h3FFF;
  localparam logic [15:0] RAM_OFS_MASK = 16'h1FFF;

  localparam int ROM_BYTES = cbc_pkg::ROM_BANK_LIMIT_DEF * cbc_pkg::ROM_BANK_BYTES;
  localparam int RAM_BYTES = cbc_pkg::RAM_BANK_LIMIT_DEF * cbc_pkg::RAM_BANK_BYTES;

  localparam int N_SETTINGS = 8;
  localparam int CALLS_PER_SETTING = 115;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 100000;

  class bank_scoreboard;
    logic [6:0] rom_mask;
    logic [2:0] ram_count;
    bit ram_en;
    bit adv_mode;
    logic [4:0] lo_bank;
    logic [1:0] hi_bank;
    bit [7:0] ram_img [RAM_BYTES];
    bit [7:0] rom_img [ROM_BYTES];
    bit rom_seen [ROM_BYTES];
    cbc_pkg::out_item_t read_q [$];
    int n_read, n_write, n_load, n_other, n_checked, n_fail;

    function new();
      rom_mask = 7'd1;
      ram_count = 3'd0;
      ram_en = 1'b0;
      adv_mode = 1'b0;
      lo_bank = 5'd1;
      hi_bank = 2'd0;
      n_read = 0;
      n_write = 0;
      n_load = 0;
      n_other = 0;
      n_checked = 0;
      n_fail = 0;
    endfunction

    function void set_reg(logic [cbc_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
      if (idx == cbc_pkg::CFG_ROM_BANK_MASK) begin
        rom_mask = value[6:0];
      end else begin
        ram_count = value[2:0];
      end
    endfunction

    function int rom_slot(logic [15:0] a);
      int bank;
      if (a < BANK1_BASE) begin
        bank = adv_mode ? int'({hi_bank, 5'd0} & rom_mask) : 0;
      end else begin
        bank = int'({hi_bank, lo_bank} & rom_mask);
      end
      bank = bank % cbc_pkg::ROM_BANK_LIMIT_DEF;
      return bank * cbc_pkg::ROM_BANK_BYTES + int'(a & ROM_OFS_MASK);
    endfunction

    function int ram_slot(logic [15:0] a);
      int bank;
      bank = 0;
      if (adv_mode && ram_count != 3'd0) begin
        bank = int'(hi_bank) & (int'(ram_count) - 1);
      end
      bank = bank % cbc_pkg::RAM_BANK_LIMIT_DEF;
      return bank * cbc_pkg::RAM_BANK_BYTES + int'((a - RAM_BASE) & RAM_OFS_MASK);
    endfunction

    function bit rom_known(logic [15:0] a);
      return rom_seen[rom_slot(a)];
    endfunction

    function bit ram_open(logic [15:0] a);
      return a >= RAM_BASE && a <= RAM_TOP && ram_en && ram_count != 3'd0;
    endfunction

    function int pending();
      return read_q.size();
    endfunction

    function void note_input(cbc_pkg::in_item_t it);
      cbc_pkg::out_item_t want;
      case (it.kind)
        cbc_pkg::KIND_READ: begin
          n_read++;
          want.read_data = cbc_pkg::FAULT_BYTE;
          want.read_fault = 1'b0;
          if (it.address <= ROM_TOP) begin
            want.read_data = rom_img[rom_slot(it.address)];
          end else if (ram_open(it.address)) begin
            want.read_data = ram_img[ram_slot(it.address)];
          end else begin
            want.read_fault = 1'b1;
          end
          read_q = {read_q, want};
        end
        cbc_pkg::KIND_WRITE: begin
          n_write++;
          if (it.address <= ENABLE_TOP) begin
            ram_en = ram_count != 3'd0 && it.data_byte[3:0] == cbc_pkg::RAM_ENABLE_KEY;
          end else if (it.address <= LOW_BANK_TOP) begin
            lo_bank = (it.data_byte[4:0] == 5'd0) ? 5'd1 : it.data_byte[4:0];
          end else if (it.address <= HIGH_BANK_TOP) begin
            hi_bank = it.data_byte[1:0];
          end else if (it.address <= ROM_TOP) begin
            adv_mode = it.data_byte[0];
          end else if (ram_open(it.address)) begin
            ram_img[ram_slot(it.address)] = it.data_byte;
          end
        end
        cbc_pkg::KIND_LOAD: begin
          n_load++;
          rom_img[it.rom_offset] = it.data_byte;
          rom_seen[it.rom_offset] = 1'b1;
        end
        default: begin
          n_other++;
        end
      endcase
    endfunction

    function void check_result(cbc_pkg::out_item_t got);
      cbc_pkg::out_item_t want;
      if (read_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) begin
          $display("Unexpected read transaction: data %02h fault %0b",
                   got.read_data, got.read_fault);
        end
      end else begin
        want = read_q.pop_front();
        n_checked++;
        if (got.read_data !== want.read_data || got.read_fault !== want.read_fault) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("Read mismatch at %0t: expected data %02h fault %0b, %s",
                     $realtime, want.read_data, want.read_fault,
                     $sformatf("got data %02h fault %0b", got.read_data, got.read_fault));
          end
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cbc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cbc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bank_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  cartridge_bank_controller_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= gaps_on && $urandom_range(0, 99) < 8;
      end
    end
  end

  function automatic cbc_pkg::in_item_t make_item(logic [1:0] k, logic [15:0] a,
                                                  logic [7:0] d, logic [20:0] o);
    cbc_pkg::in_item_t it;
    it.kind = k;
    it.address = a;
    it.data_byte = d;
    it.rom_offset = o;
    return it;
  endfunction

  function automatic logic [15:0] ram_addr();
    return RAM_BASE + ($urandom_range(0, 1) ? 16'($urandom_range(0, 15))
                                            : 16'($urandom_range(0, 16'h1FFF)));
  endfunction

  task automatic send_item(input cbc_pkg::in_item_t it);
    @(negedge clk);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
  endtask

  // A ROM byte that was never loaded must not be read, so load it first.
  task automatic send_read(input logic [15:0] a);
    if (a <= ROM_TOP && !sb.rom_known(a)) begin
      send_item(make_item(cbc_pkg::KIND_LOAD, 16'($urandom), 8'($urandom),
                          21'(sb.rom_slot(a))));
    end
    send_item(make_item(cbc_pkg::KIND_READ, a, 8'($urandom), 21'($urandom)));
  endtask

  task automatic send_write(input logic [15:0] a, input logic [7:0] d);
    send_item(make_item(cbc_pkg::KIND_WRITE, a, d, 21'($urandom)));
  endtask

  task automatic write_reg(input logic [cbc_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[cbc_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic issue_random();
    int unsigned pick;
    int unsigned sel;
    logic [15:0] a;
    logic [7:0] d;
    logic [20:0] o;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    d = 8'($urandom);
    if (pick < 40) begin
      if (sel < 45) begin
        a = {1'b0, 1'($urandom),
             ($urandom_range(0, 1) ? 14'($urandom_range(0, 15)) : 14'($urandom))};
      end else if (sel < 80) begin
        a = ram_addr();
      end else begin
        a = 16'($urandom);
      end
      send_read(a);
    end else if (pick < 75) begin
      if (sel < 60) begin
        a = {1'b0, 15'($urandom)};
        if (a <= ENABLE_TOP && $urandom_range(0, 1) == 0) begin
          d[3:0] = cbc_pkg::RAM_ENABLE_KEY;
        end else if (a > ENABLE_TOP && a <= LOW_BANK_TOP && $urandom_range(0, 5) == 0) begin
          d[4:0] = 5'd0;
        end
      end else if (sel < 90) begin
        a = ram_addr();
      end else begin
        a = 16'($urandom);
      end
      send_write(a, d);
    end else if (pick < 95) begin
      o = $urandom_range(0, 1) ? {7'($urandom), 10'd0, 4'($urandom)} : 21'($urandom);
      send_item(make_item(cbc_pkg::KIND_LOAD, 16'($urandom), d, o));
    end else begin
      send_item(make_item(KIND_UNUSED, 16'($urandom), d, 21'($urandom)));
    end
  endtask

  initial begin
    int mask_tab [N_SETTINGS];
    int count_tab [N_SETTINGS];
    int unsigned mask;
    // A zero mask entry means a random mask is drawn for that setting.
    mask_tab = '{127, 1, 31, 63, 127, 0, 0, 127};
    count_tab = '{4, 0, 1, 2, 7, 3, 5, 6};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall);

    for (int p = 0; p < N_SETTINGS; p++) begin
      wait_idle();
      mask = (mask_tab[p] == 0) ? $urandom_range(1, 127) : mask_tab[p];
      write_reg(cbc_pkg::CFG_ROM_BANK_MASK, mask);
      write_reg(cbc_pkg::CFG_RAM_BANK_COUNT, count_tab[p]);
      gaps_on = (p != 2);
      hold_req = (p == 1 || p == 5);

      if (p == 0) begin
        send_item(make_item(cbc_pkg::KIND_LOAD, 16'h0000, 8'h00, 21'h000000));
        send_item(make_item(cbc_pkg::KIND_LOAD, 16'hFFFF, 8'hFF, 21'h1FFFFF));
        send_read(16'h0000);
        send_write(16'h2000, 8'h00);
        send_read(16'h4000);
        send_write(16'h3FFF, 8'hFF);
        send_write(16'h4000, 8'h03);
        send_read(16'h7FFF);
        send_write(16'h6000, 8'h01);
        send_read(16'h0000);
        send_read(16'hA000);
        send_write(16'hA000, 8'h55);
        send_write(16'h0000, 8'h0A);
        send_read(16'hA000);
        send_write(16'hBFFF, 8'hA5);
        send_read(16'hBFFF);
        send_read(16'h8000);
        send_read(16'h9FFF);
        send_read(16'hC000);
        send_read(16'hFFFF);
        send_item(make_item(KIND_UNUSED, 16'h1234, 8'h5A, 21'h0ABCDE));
        send_write(16'h7FFF, 8'h00);
        send_read(16'hBFFF);
        send_write(16'h1FFF, 8'h00);
        send_read(16'hA000);
      end

      repeat (CALLS_PER_SETTING) issue_random();
      // Write the RAM enable key; RAM is left enabled unless the RAM bank count is zero.
      send_write(16'h0000, {4'h0, cbc_pkg::RAM_ENABLE_KEY});
    end

    wait_idle();
    $display("Covered %0d reads, %0d writes, %0d ROM loads, %0d unused-kind transactions",
             sb.n_read, sb.n_write, sb.n_load, sb.n_other);
    $display("over %0d register settings; %0d results checked, %0d mismatches.",
             N_SETTINGS, sb.n_checked, sb.n_fail);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
